// ===== src/pdps_pkg.sv =====
// Shared types, constants and pattern tables for the percent-decode pattern screen.
// No dependencies; every other file imports this package.
package pdps_pkg;

  localparam int ByteW       = 8;
  localparam int TypeW       = 16;
  localparam int NumPatterns = 4;
  localparam int PatIdxW     = 2;
  localparam int ProgW       = 3;
  localparam int NumTypeRegs = 7;
  localparam int CfgIdxW     = 3;
  localparam int MaxFeeds    = 3;

  localparam logic [ByteW-1:0] PctChar   = 8'h25;
  localparam logic [ByteW-1:0] SpaceChar = 8'h20;
  localparam logic [ByteW-1:0] CtrlMax   = 8'h1f;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PEER_ID  = 3'd0,
    REG_NAME     = 3'd1,
    REG_PATH     = 3'd2,
    REG_TITLE    = 3'd3,
    REG_SUBJECT  = 3'd4,
    REG_LOCATION = 3'd5,
    REG_VERSION  = 3'd6
  } cfg_reg_e;

  // Escape decoder phase
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HELD = 2'd2
  } esc_phase_e;

  // Decoded characters produced by one byte, in feed order
  typedef struct packed {
    logic [MaxFeeds-1:0]            valid;
    logic [MaxFeeds-1:0][ByteW-1:0] chars;
    logic                           last;
  } dec_chars_t;

  // Matcher state for one string
  typedef struct packed {
    logic [NumPatterns-1:0][ProgW-1:0] prog;
    logic                              found;
    logic [PatIdxW-1:0]                pat;
  } match_state_t;

  // Verdict handed back to the top level
  typedef struct packed {
    logic               found;
    logic [PatIdxW-1:0] pat;
  } verdict_t;

  // Pattern characters: "<!e", "<!E", "PD94bW", "PHN2Zy"
  function automatic logic [ByteW-1:0] pat_char(input logic [PatIdxW-1:0] p,
                                                input logic [ProgW-1:0] k);
    logic [ByteW-1:0] c;
    c = '0;
    case ({p, k})
      5'b00_000: c = 8'h3c;
      5'b00_001: c = 8'h21;
      5'b00_010: c = 8'h65;
      5'b01_000: c = 8'h3c;
      5'b01_001: c = 8'h21;
      5'b01_010: c = 8'h45;
      5'b10_000: c = 8'h50;
      5'b10_001: c = 8'h44;
      5'b10_010: c = 8'h39;
      5'b10_011: c = 8'h34;
      5'b10_100: c = 8'h62;
      5'b10_101: c = 8'h57;
      5'b11_000: c = 8'h50;
      5'b11_001: c = 8'h48;
      5'b11_010: c = 8'h4e;
      5'b11_011: c = 8'h32;
      5'b11_100: c = 8'h5a;
      5'b11_101: c = 8'h79;
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [ProgW-1:0] pat_len(input logic [PatIdxW-1:0] p);
    return p[1] ? 3'd6 : 3'd3;
  endfunction

endpackage

// ===== src/pdps_if.sv =====
// Channel interfaces of the percent-decode pattern screen: input, result and config.
// Depends on pdps_pkg for field widths.
interface pdps_in_if import pdps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;
  logic [TypeW-1:0] string_type;

  modport source (output valid, data_byte, last_byte, string_type, input ready);
  modport sink   (input valid, data_byte, last_byte, string_type, output ready);
endinterface

interface pdps_out_if import pdps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   out_byte;
  logic               end_of_string;
  logic               suspicious;
  logic [PatIdxW-1:0] pattern_index;

  modport source (output valid, out_byte, end_of_string, suspicious, pattern_index,
                  input ready);
  modport sink   (input valid, out_byte, end_of_string, suspicious, pattern_index,
                  output ready);
endinterface

interface pdps_cfg_if import pdps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TypeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pdps_decoder.sv =====
// Percent decoder: turns each raw byte into up to three decoded characters.
// Holds the escape phase and the held byte; depends on pdps_pkg.
module pdps_decoder import pdps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output dec_chars_t       dec_o
);

  esc_phase_e       phase_q, phase_d, ph;
  logic [ByteW-1:0] held_q, held_d, hd;
  logic [4:0]       hex_h, hex_b;
  logic [1:0]       n;
  dec_chars_t       dec;

  // Value of a hex digit, or 16 if the byte is not one
  function automatic logic [4:0] hex_val(input logic [ByteW-1:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  // Decode one byte, then flush any pending escape on the last byte
  always_comb begin
    dec   = '0;
    n     = '0;
    ph    = phase_q;
    hd    = held_q;
    hex_h = hex_val(held_q);
    hex_b = hex_val(byte_i);
    case (phase_q)
      ESC_PCT: begin
        hd = byte_i;
        ph = ESC_HELD;
      end
      ESC_HELD: begin
        if (!hex_h[4] && !hex_b[4]) begin
          dec.chars[n] = {hex_h[3:0], hex_b[3:0]};
          dec.valid[n] = 1'b1;
          n            = n + 2'd1;
          ph           = ESC_IDLE;
        end else begin
          // escape failed: '%' is literal, resume after it
          dec.chars[n] = PctChar;
          dec.valid[n] = 1'b1;
          n            = n + 2'd1;
          if (held_q == PctChar) begin
            hd = byte_i;
            ph = ESC_HELD;
          end else begin
            dec.chars[n] = held_q;
            dec.valid[n] = 1'b1;
            n            = n + 2'd1;
            if (byte_i == PctChar) begin
              ph = ESC_PCT;
            end else begin
              dec.chars[n] = byte_i;
              dec.valid[n] = 1'b1;
              n            = n + 2'd1;
              ph           = ESC_IDLE;
            end
          end
        end
      end
      default: begin
        if (byte_i == PctChar) begin
          ph = ESC_PCT;
        end else begin
          dec.chars[n] = byte_i;
          dec.valid[n] = 1'b1;
          n            = n + 2'd1;
          ph           = ESC_IDLE;
        end
      end
    endcase
    if (last_i) begin
      if (ph == ESC_PCT) begin
        dec.chars[n] = PctChar;
        dec.valid[n] = 1'b1;
      end else if (ph == ESC_HELD) begin
        dec.chars[n] = PctChar;
        dec.valid[n] = 1'b1;
        n            = n + 2'd1;
        dec.chars[n] = hd;
        dec.valid[n] = 1'b1;
      end
    end
    dec.last = last_i;
  end

  assign dec_o = dec;

  // Advance the escape state; clear it at the end of a string
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (adv_i) begin
      phase_d = last_i ? ESC_IDLE : ph;
      held_d  = last_i ? '0 : hd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ESC_IDLE;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== src/pdps_matcher.sv =====
// Pattern matcher: runs up to three decoded characters per byte through four matchers.
// Holds match progress and the verdict so far; depends on pdps_pkg.
module pdps_matcher import pdps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  dec_chars_t dec_i,
  output verdict_t   verdict_o
);

  match_state_t state_q, state_d;
  match_state_t s1, s2, s3;

  // Advance every matcher by one decoded character
  function automatic match_state_t feed(input match_state_t s, input logic [ByteW-1:0] c);
    match_state_t     r;
    logic [ProgW-1:0] k;
    r = s;
    for (int p = 0; p < NumPatterns; p++) begin
      k = r.prog[p];
      if (k >= pat_len(p[PatIdxW-1:0])) k = '0;
      if (pat_char(p[PatIdxW-1:0], k) == c) k = k + 3'd1;
      else k = (pat_char(p[PatIdxW-1:0], '0) == c) ? 3'd1 : 3'd0;
      if (k == pat_len(p[PatIdxW-1:0])) begin
        if (!r.found || p[PatIdxW-1:0] < r.pat) r.pat = p[PatIdxW-1:0];
        r.found = 1'b1;
        k       = '0;
      end
      r.prog[p] = k;
    end
    return r;
  endfunction

  // Chain the three feed slots
  always_comb begin
    s1 = dec_i.valid[0] ? feed(state_q, dec_i.chars[0]) : state_q;
    s2 = dec_i.valid[1] ? feed(s1, dec_i.chars[1]) : s1;
    s3 = dec_i.valid[2] ? feed(s2, dec_i.chars[2]) : s2;
  end

  assign verdict_o.found = s3.found;
  assign verdict_o.pat   = s3.found ? s3.pat : '0;

  // Hold, advance or clear at the end of a string
  always_comb begin
    state_d = state_q;
    if (adv_i) state_d = dec_i.last ? '0 : s3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/percent_decode_pattern_screen_top.sv =====
// Percent-decode pattern screen, top level: input register, config registers,
// sanitizer and result register. Depends on pdps_pkg, pdps_if, pdps_decoder, pdps_matcher.
//
// Takes one raw string byte per word and returns one result word per byte, one
// word per clock cycle sustained while the result port is not stalled; a byte passes
// through the input register and then the result register. A single decode-and-match
// pass lies between the two and chains three character steps of the four pattern
// matchers. Bytes 1..31 are echoed as spaces for type 0 and the seven configured
// types; the word of the last byte carries the verdict on the decoded string.
// The config port is always ready; write it only while the block is idle.
module percent_decode_pattern_screen_top import pdps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdps_in_if.sink    in_i,
  pdps_out_if.source out_o,
  pdps_cfg_if.sink   cfg_i
);

  logic [NumTypeRegs-1:0][TypeW-1:0] type_q;
  logic                              s1_valid_q, s1_valid_d;
  logic [ByteW-1:0]                  s1_byte_q;
  logic                              s1_last_q;
  logic [TypeW-1:0]                  s1_type_q;
  logic                              out_valid_q, out_valid_d;
  logic [ByteW-1:0]                  out_byte_q;
  logic                              out_end_q, out_susp_q;
  logic [PatIdxW-1:0]                out_pat_q;
  logic                              in_fire, out_free, adv, plain;
  logic [ByteW-1:0]                  san_byte;
  dec_chars_t                        dec;
  verdict_t                          verdict;

  // Handshake control
  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign s1_valid_d  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
      s1_type_q <= in_i.string_type;
    end
  end

  // Config registers; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PEER_ID:  type_q[REG_PEER_ID]  <= cfg_i.data;
        REG_NAME:     type_q[REG_NAME]     <= cfg_i.data;
        REG_PATH:     type_q[REG_PATH]     <= cfg_i.data;
        REG_TITLE:    type_q[REG_TITLE]    <= cfg_i.data;
        REG_SUBJECT:  type_q[REG_SUBJECT]  <= cfg_i.data;
        REG_LOCATION: type_q[REG_LOCATION] <= cfg_i.data;
        REG_VERSION:  type_q[REG_VERSION]  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sanitize control bytes of plain-text types
  always_comb begin
    plain = (s1_type_q == '0);
    for (int i = 0; i < NumTypeRegs; i++) begin
      if (s1_type_q == type_q[i]) plain = 1'b1;
    end
    san_byte = s1_byte_q;
    if (plain && s1_byte_q != '0 && s1_byte_q <= CtrlMax) san_byte = SpaceChar;
  end

  pdps_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .dec_o  (dec)
  );

  pdps_matcher u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .dec_i     (dec),
    .verdict_o (verdict)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= san_byte;
      out_end_q  <= s1_last_q;
      out_susp_q <= s1_last_q & verdict.found;
      out_pat_q  <= s1_last_q ? verdict.pat : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.end_of_string = out_end_q;
  assign out_o.suspicious    = out_susp_q;
  assign out_o.pattern_index = out_pat_q;

endmodule

// ===== src/pdps_checker.sv =====
// Port-level assertions for the percent-decode pattern screen, bound to the top level.
// Depends on pdps_pkg and percent_decode_pattern_screen_top.
module pdps_checker import pdps_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ByteW-1:0]   out_byte_i,
  input logic               out_end_i,
  input logic               out_susp_i,
  input logic [PatIdxW-1:0] out_pat_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(out_end_i) && $stable(out_susp_i) && $stable(out_pat_i))
    else $error("result word changed while stalled");

  // Verdict only on the last byte
  a_verdict_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_end_i |-> !out_susp_i && out_pat_i == '0)
    else $error("verdict shown before end of string");

  // No pattern index without a hit
  a_index_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_susp_i |-> out_pat_i == '0)
    else $error("pattern index set without a hit");

  // An empty result register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind percent_decode_pattern_screen_top pdps_checker u_pdps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_end_i   (out_o.end_of_string),
  .out_susp_i  (out_o.suspicious),
  .out_pat_i   (out_o.pattern_index)
);
